>>> hw/rtl/rbe_pkg.sv
// package for the report-by-exception filter
// types, command and register codes, change test; no dependencies
package rbe_pkg;

  localparam int VALUE_BITS = 48;
  localparam int TIME_BITS  = 63;
  localparam int CODE_BITS  = 64;
  localparam int AMT_BITS   = 47;
  localparam int IVL_BITS   = 62;
  localparam int CFG_BITS   = 62;
  localparam int IDX_BITS   = 3;
  localparam int PROD_BITS  = 96;
  localparam int SEG_BITS   = 16;
  localparam int SEGS       = VALUE_BITS / SEG_BITS;
  localparam int STEP_BITS  = 2;
  localparam logic [22:0] PCT_SCALE = 23'd6553600;

  typedef enum logic [1:0] {
    CMD_OFFER  = 2'd0,
    CMD_DUE    = 2'd1,
    CMD_NODATA = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_CHG_ONLY  = 3'd0,
    REG_DB_MODE   = 3'd1,
    REG_DB_AMOUNT = 3'd2,
    REG_MIN_IVL   = 3'd3,
    REG_MAX_IVL   = 3'd4,
    REG_DEBOUNCE  = 3'd5
  } reg_idx_t;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ABS  = 2'd1;
  localparam logic [1:0] MODE_PCT  = 2'd2;

  typedef struct packed {
    logic [1:0]                   command;
    logic [TIME_BITS-1:0]         now;
    logic                         reading_is_num;
    logic                         reading_is_nan;
    logic signed [VALUE_BITS-1:0] reading_value;
    logic [CODE_BITS-1:0]         reading_code;
    logic [1:0]                   quality;
    logic                         pushed;
  } in_item_t;

  typedef struct packed {
    logic                         published;
    logic                         read_request;
    logic                         out_is_num;
    logic                         out_is_nan;
    logic signed [VALUE_BITS-1:0] out_value;
    logic [CODE_BITS-1:0]         out_code;
    logic [1:0]                   out_quality;
  } out_item_t;

  typedef struct packed {
    logic                 chg_only;
    logic [1:0]           deadband_mode;
    logic [AMT_BITS-1:0]  deadband_amount;
    logic [IVL_BITS-1:0]  min_gap;
    logic [IVL_BITS-1:0]  max_gap;
    logic [IVL_BITS-1:0]  debounce_time;
  } cfg_t;

  typedef struct packed {
    logic                         is_num;
    logic                         is_nan;
    logic signed [VALUE_BITS-1:0] value;
    logic [CODE_BITS-1:0]         code;
  } rdg_t;

  // bprod is amt times the magnitude of b, built beforehand
  function automatic logic changed_f(rdg_t o, rdg_t b, logic [1:0] mode,
                                     logic [AMT_BITS-1:0] amt,
                                     logic [PROD_BITS-1:0] bprod);
    logic signed [VALUE_BITS:0] diff;
    logic [VALUE_BITS:0]        d;
    logic [PROD_BITS-1:0]       p1;
    logic                       res;
    diff = {o.value[VALUE_BITS-1], o.value} - {b.value[VALUE_BITS-1], b.value};
    d    = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : (VALUE_BITS+1)'(diff);
    p1   = PROD_BITS'(d) * PROD_BITS'(PCT_SCALE);
    if (o.is_num && b.is_num) begin
      if (o.is_nan || b.is_nan) begin
        res = o.is_nan != b.is_nan;
      end else begin
        case (mode)
          MODE_ABS: res = d >= (VALUE_BITS+1)'(amt);
          MODE_PCT: res = (b.value == '0) ? (d != '0) : (p1 >= bprod);
          default:  res = d != '0;
        endcase
      end
    end else if (!o.is_num && !b.is_num) begin
      res = o.code != b.code;
    end else begin
      res = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [TIME_BITS-1:0] elapsed_f(logic [TIME_BITS-1:0] now,
                                                     logic [TIME_BITS-1:0] ref_t);
    return (now > ref_t) ? now - ref_t : '0;
  endfunction

endpackage

>>> hw/rtl/rbe_if.sv
// valid/ready channel interfaces for input and result items
// depends on rbe_pkg
interface rbe_in_if;
  import rbe_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbe_out_if;
  import rbe_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/rbe_core.sv
// filter state and decision logic for one item
// percent deadband products built one segment at a time; depends on rbe_pkg
module rbe_core (
  input  logic              clk,
  input  logic              rst_n,
  input  rbe_pkg::cfg_t     cfg,
  input  logic              cfg_we,
  input  logic              fire,
  input  rbe_pkg::in_item_t item,
  output rbe_pkg::out_item_t result,
  output logic              busy
);
  import rbe_pkg::*;

  logic                 has_last_r, has_last_nxt;
  rdg_t                 last_r, last_nxt;
  logic [1:0]           last_q_r, last_q_nxt;
  logic [TIME_BITS-1:0] last_pub_r, last_pub_nxt;
  logic [TIME_BITS-1:0] origin_r, origin_nxt;
  logic                 has_pend_r, has_pend_nxt;
  rdg_t                 pend_r, pend_nxt;
  logic                 has_cand_r, has_cand_nxt;
  rdg_t                 first_r, first_nxt;
  logic [TIME_BITS-1:0] cand_since_r, cand_since_nxt;
  rdg_t                 latest_r, latest_nxt;
  logic                 has_read_r, has_read_nxt;
  logic [TIME_BITS-1:0] last_read_r, last_read_nxt;
  logic                 unread_r, unread_nxt;

  logic                 busy_r;
  logic [STEP_BITS-1:0] step_r;
  logic [PROD_BITS-1:0] prod_last_r, prod_first_r;
  logic [VALUE_BITS-1:0] abs_last, abs_first;
  logic [SEG_BITS-1:0]  seg_last, seg_first;
  logic [AMT_BITS+SEG_BITS-1:0] part_last, part_first;
  logic [PROD_BITS-1:0] add_last, add_first;
  logic                 recalc;

  logic [1:0]           mode;
  logic                 filters;
  logic [TIME_BITS-1:0] maxi, mini, deb, sp, pa, ra, rref, nw;
  rdg_t                 rd, held;
  logic                 chg, chg_first, chg_held, pub, rr, done;
  logic [1:0]           pq;

  assign busy = busy_r;

  // amount times magnitude of the last and first readings, one segment a cycle
  always_comb begin
    abs_last  = last_r.value[VALUE_BITS-1] ? VALUE_BITS'(-last_r.value)
                                           : VALUE_BITS'(last_r.value);
    abs_first = first_r.value[VALUE_BITS-1] ? VALUE_BITS'(-first_r.value)
                                            : VALUE_BITS'(first_r.value);
    seg_last   = SEG_BITS'(abs_last >> (SEG_BITS * int'(step_r)));
    seg_first  = SEG_BITS'(abs_first >> (SEG_BITS * int'(step_r)));
    part_last  = {{SEG_BITS{1'b0}}, cfg.deadband_amount} * {{AMT_BITS{1'b0}}, seg_last};
    part_first = {{SEG_BITS{1'b0}}, cfg.deadband_amount} * {{AMT_BITS{1'b0}}, seg_first};
    add_last   = prod_last_r + (PROD_BITS'(part_last) << (SEG_BITS * int'(step_r)));
    add_first  = prod_first_r + (PROD_BITS'(part_first) << (SEG_BITS * int'(step_r)));
    recalc     = cfg_we || (fire && mode == MODE_PCT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; step_r <= '0; prod_last_r <= '0; prod_first_r <= '0;
    end else if (recalc) begin
      busy_r <= 1'b1; step_r <= '0; prod_last_r <= '0; prod_first_r <= '0;
    end else if (busy_r) begin
      prod_last_r  <= add_last;
      prod_first_r <= add_first;
      if (step_r == STEP_BITS'(SEGS - 1)) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_comb begin
    mode = (cfg.deadband_amount == '0 || cfg.deadband_mode > MODE_PCT) ? MODE_NONE
                                                                       : cfg.deadband_mode;
    filters = cfg.chg_only || (mode != MODE_NONE) || (cfg.debounce_time != '0);
    mini = TIME_BITS'(cfg.min_gap);
    deb  = TIME_BITS'(cfg.debounce_time);
    if (cfg.min_gap != '0 && cfg.max_gap != '0 &&
        cfg.max_gap <= cfg.min_gap) begin
      maxi = {cfg.min_gap, 1'b0};
    end else begin
      maxi = TIME_BITS'(cfg.max_gap);
    end
    nw = item.now;
    rd.is_num = item.reading_is_num;
    rd.is_nan = item.reading_is_num & item.reading_is_nan;
    rd.value  = (item.reading_is_num && !item.reading_is_nan) ? item.reading_value : '0;
    rd.code   = item.reading_is_num ? '0 : item.reading_code;
    sp = elapsed_f(nw, has_last_r ? last_pub_r : origin_r);
    chg       = changed_f(rd, last_r, mode, cfg.deadband_amount, prod_last_r);
    chg_first = changed_f(rd, first_r, mode, cfg.deadband_amount, prod_first_r);
    held = '0;
    if (has_pend_r && mini != '0 && sp >= mini) begin
      held = pend_r;
    end else begin
      held = latest_r;
    end
    chg_held = changed_f(held, last_r, mode, cfg.deadband_amount, prod_last_r);

    has_last_nxt = has_last_r; last_nxt = last_r; last_q_nxt = last_q_r;
    last_pub_nxt = last_pub_r; origin_nxt = origin_r;
    has_pend_nxt = has_pend_r; pend_nxt = pend_r;
    has_cand_nxt = has_cand_r; first_nxt = first_r; cand_since_nxt = cand_since_r;
    latest_nxt = latest_r; has_read_nxt = has_read_r; last_read_nxt = last_read_r;
    unread_nxt = unread_r;
    pub = 1'b0; rr = 1'b0; done = 1'b0; pq = item.quality;
    pa = '0; ra = '0; rref = '0;

    case (item.command)
      CMD_RESET: begin
        has_last_nxt = 1'b0; last_nxt = '0; last_q_nxt = '0; last_pub_nxt = '0;
        has_pend_nxt = 1'b0; pend_nxt = '0; has_cand_nxt = 1'b0; first_nxt = '0;
        cand_since_nxt = '0; latest_nxt = '0; has_read_nxt = 1'b0;
        last_read_nxt = '0; unread_nxt = 1'b0; origin_nxt = nw;
        held = '0;
      end
      CMD_NODATA: begin
        unread_nxt = 1'b1;
      end
      CMD_OFFER: begin
        held = rd;
        if (!has_last_r || last_q_r != item.quality || (maxi != '0 && sp >= maxi)) begin
          pub = 1'b1;
        end else begin
          if (deb != '0) begin
            if (!chg) begin
              has_cand_nxt = 1'b0;
              has_pend_nxt = 1'b0;
              done = 1'b1;
            end else begin
              latest_nxt = rd;
              if (has_cand_r && !chg_first) begin
                if (elapsed_f(nw, cand_since_r) < deb) begin
                  done = 1'b1;
                end else begin
                  has_cand_nxt = 1'b0;
                end
              end else begin
                first_nxt = rd;
                cand_since_nxt = nw;
                has_cand_nxt = 1'b1;
                done = 1'b1;
              end
            end
          end
          if (!done) begin
            if (mini != '0 && sp < mini) begin
              pend_nxt = rd;
              has_pend_nxt = 1'b1;
            end else begin
              has_pend_nxt = 1'b0;
              pub = !(filters && !chg);
            end
          end
        end
        if (pub) begin
          last_nxt = rd; last_q_nxt = item.quality; has_last_nxt = 1'b1;
          last_pub_nxt = nw; has_pend_nxt = 1'b0; has_cand_nxt = 1'b0;
        end
      end
      default: begin
        pq = last_q_r;
        if (mini != '0 && has_pend_r && sp >= mini) begin
          has_pend_nxt = 1'b0;
          pub = has_last_r && !(filters && !chg_held);
        end
        if (!pub && deb != '0 && has_cand_r && elapsed_f(nw, cand_since_r) >= deb) begin
          held = latest_r;
          has_cand_nxt = 1'b0;
          if (mini != '0 && sp < mini) begin
            pend_nxt = latest_r;
            has_pend_nxt = 1'b1;
          end else begin
            pub = has_last_r && !(filters && !changed_f(latest_r, last_r, mode,
                                                        cfg.deadband_amount,
                                                        prod_last_r));
          end
        end
        if (pub) begin
          last_nxt = held; has_last_nxt = 1'b1; last_pub_nxt = nw;
          has_pend_nxt = 1'b0; has_cand_nxt = 1'b0;
        end
        pa = pub ? nw : (has_last_r ? last_pub_r : origin_r);
        ra = has_read_r ? last_read_r : origin_r;
        rref = (pa > ra) ? pa : ra;
        if (maxi != '0 && item.pushed && !unread_r && elapsed_f(nw, rref) >= maxi) begin
          last_read_nxt = nw;
          has_read_nxt = 1'b1;
          rr = 1'b1;
        end
      end
    endcase

    result.published    = pub;
    result.read_request = rr;
    result.out_is_num   = pub & held.is_num;
    result.out_is_nan   = pub & held.is_nan;
    result.out_value    = pub ? held.value : '0;
    result.out_code     = pub ? held.code : '0;
    result.out_quality  = pub ? pq : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_last_r <= 1'b0; last_r <= '0; last_q_r <= '0; last_pub_r <= '0;
      origin_r <= '0; has_pend_r <= 1'b0; pend_r <= '0; has_cand_r <= 1'b0;
      first_r <= '0; cand_since_r <= '0; latest_r <= '0; has_read_r <= 1'b0;
      last_read_r <= '0; unread_r <= 1'b0;
    end else if (fire) begin
      has_last_r <= has_last_nxt; last_r <= last_nxt; last_q_r <= last_q_nxt;
      last_pub_r <= last_pub_nxt; origin_r <= origin_nxt;
      has_pend_r <= has_pend_nxt; pend_r <= pend_nxt;
      has_cand_r <= has_cand_nxt; first_r <= first_nxt; cand_since_r <= cand_since_nxt;
      latest_r <= latest_nxt; has_read_r <= has_read_nxt; last_read_r <= last_read_nxt;
      unread_r <= unread_nxt;
    end
  end

endmodule

>>> hw/rtl/report_by_exception_filter_top.sv
// report-by-exception filter: one result item per input item
// input and result items are registered; one item per cycle unless the core is busy or
// the result channel stalls; each register write, and in percent deadband mode each item,
// holds the decision logic while the amount products are rebuilt, and items wait meanwhile
// synchronous active-low reset clears filter state and registers; no clearing pass
// depends on rbe_pkg, rbe_if and rbe_core
module report_by_exception_filter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  rbe_in_if.sink                        in_if,
  rbe_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [rbe_pkg::IDX_BITS-1:0]  cfg_index,
  input  logic [rbe_pkg::CFG_BITS-1:0]  cfg_data
);
  import rbe_pkg::*;

  cfg_t      cfg_r;
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      core_busy;
  logic      fire;

  assign fire        = in_valid_r && !core_busy && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || fire;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHG_ONLY:  cfg_r.chg_only        <= cfg_data[0];
        REG_DB_MODE:   cfg_r.deadband_mode   <= cfg_data[1:0];
        REG_DB_AMOUNT: cfg_r.deadband_amount <= cfg_data[AMT_BITS-1:0];
        REG_MIN_IVL:   cfg_r.min_gap         <= cfg_data[IVL_BITS-1:0];
        REG_MAX_IVL:   cfg_r.max_gap         <= cfg_data[IVL_BITS-1:0];
        REG_DEBOUNCE:  cfg_r.debounce_time   <= cfg_data[IVL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_valid_r <= in_if.valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_item_r <= in_if.data;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  rbe_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .cfg_we (cfg_we),
    .fire   (fire),
    .item   (in_item_r),
    .result (result),
    .busy   (core_busy)
  );

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> out_valid_r && $stable(out_item_r))
    else $error("result item lost under stall");
  a_rr_due: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_item_r.command != CMD_DUE |=> !out_item_r.read_request)
    else $error("read request outside due check");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.published && out_item_r.read_request))
    else $error("publish and read request together");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.published |-> out_item_r.out_value == '0 &&
      out_item_r.out_code == '0 && out_item_r.out_quality == '0)
    else $error("unpublished result not zero");
`endif

endmodule

>>> test/tb_report_by_exception_filter_top.sv
// testbench for report_by_exception_filter_top: random and directed command items
// against a cycle-free predictor of the filter, with random stalls on both channels
// depends on rbe_pkg, rbe_if and the filter top level
module tb_report_by_exception_filter_top;
  import rbe_pkg::*;

  localparam int LIMIT = 400000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  rbe_in_if  in_ch ();
  rbe_out_if out_ch ();

  report_by_exception_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  in_item_t  item_q[$];
  out_item_t report_q[$];
  int        fails;
  int        cycles;
  logic      in_fire;
  logic      pause_tx;
  logic      hold_go;
  logic      hold_done;
  int        hold_left;
  logic      calm;

  // mirrored configuration
  logic                c_chg_only;
  logic [1:0]          c_mode;
  logic [AMT_BITS-1:0] c_amount;
  logic [IVL_BITS-1:0] c_min;
  logic [IVL_BITS-1:0] c_max;
  logic [IVL_BITS-1:0] c_deb;

  // mirrored filter state
  logic                 m_has_last, m_has_pend, m_has_cand, m_has_read, m_unreadable;
  rdg_t                 m_last, m_pend, m_first, m_latest;
  logic [1:0]           m_last_q;
  logic [TIME_BITS-1:0] m_last_pub, m_origin, m_cand_since, m_last_read;

  // stimulus state
  logic [TIME_BITS-1:0]         t_now;
  longint unsigned              t_span;
  logic signed [VALUE_BITS-1:0] base_val;
  logic [CODE_BITS-1:0]         base_code;
  logic [1:0]                   cur_q;

  always #5 clk = ~clk;

  function automatic void clear_filter();
    m_has_last = 0; m_has_pend = 0; m_has_cand = 0; m_has_read = 0; m_unreadable = 0;
    m_last = '0; m_pend = '0; m_first = '0; m_latest = '0; m_last_q = '0;
    m_last_pub = '0; m_origin = '0; m_cand_since = '0; m_last_read = '0;
  endfunction

  function automatic logic [1:0] eff_mode();
    if (c_amount == '0 || c_mode > MODE_PCT) return MODE_NONE;
    return c_mode;
  endfunction

  function automatic logic filters_on();
    return c_chg_only || eff_mode() != MODE_NONE || c_deb != '0;
  endfunction

  function automatic logic [63:0] eff_max();
    if (c_min != '0 && c_max != '0 && c_max <= c_min) return {1'b0, c_min, 1'b0};
    return {2'b0, c_max};
  endfunction

  function automatic logic [TIME_BITS-1:0] gap(logic [TIME_BITS-1:0] a,
                                               logic [TIME_BITS-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [TIME_BITS-1:0] since_pub(logic [TIME_BITS-1:0] now);
    return gap(now, m_has_last ? m_last_pub : m_origin);
  endfunction

  function automatic logic differs(rdg_t o, rdg_t b);
    logic signed [VALUE_BITS:0] diff;
    logic signed [VALUE_BITS:0] bx;
    logic [VALUE_BITS:0]        d;
    logic [VALUE_BITS:0]        absb;
    logic [127:0]               lhs;
    logic [127:0]               rhs;
    if (o.is_num && b.is_num) begin
      if (o.is_nan || b.is_nan) return o.is_nan != b.is_nan;
      diff = o.value;
      diff = diff - b.value;
      bx   = b.value;
      d    = diff[VALUE_BITS] ? -diff : diff;
      absb = bx[VALUE_BITS] ? -bx : bx;
      lhs  = 128'(d) * 128'd6553600;
      rhs  = 128'(c_amount) * 128'(absb);
      case (eff_mode())
        MODE_ABS: return d >= 49'(c_amount);
        MODE_PCT: return (b.value == '0) ? (d != '0) : (lhs >= rhs);
        default:  return d != '0;
      endcase
    end
    if (!o.is_num && !b.is_num) return o.code != b.code;
    return 1'b1;
  endfunction

  function automatic void store_pub(rdg_t x, logic [1:0] q, logic [TIME_BITS-1:0] now);
    m_last = x; m_last_q = q; m_has_last = 1; m_last_pub = now;
    m_has_pend = 0; m_has_cand = 0;
  endfunction

  function automatic out_item_t pub_item(rdg_t x, logic [1:0] q);
    out_item_t r;
    r = '0;
    r.published   = 1;
    r.out_is_num  = x.is_num;
    r.out_is_nan  = x.is_nan;
    r.out_value   = x.value;
    r.out_code    = x.code;
    r.out_quality = q;
    return r;
  endfunction

  function automatic logic release_held(rdg_t x, logic [TIME_BITS-1:0] now);
    if (!m_has_last || (filters_on() && !differs(x, m_last))) return 1'b0;
    store_pub(x, m_last_q, now);
    return 1'b1;
  endfunction

  function automatic out_item_t predict_report(in_item_t it);
    out_item_t            r;
    rdg_t                 rd;
    rdg_t                 held;
    logic [63:0]          mx;
    logic                 chg;
    logic                 pub;
    logic                 rr;
    logic [TIME_BITS-1:0] refp;
    logic [TIME_BITS-1:0] ra;
    r         = '0;
    rd.is_num = it.reading_is_num;
    rd.is_nan = it.reading_is_num & it.reading_is_nan;
    rd.value  = (rd.is_num && !rd.is_nan) ? it.reading_value : '0;
    rd.code   = rd.is_num ? '0 : it.reading_code;
    mx        = eff_max();
    case (cmd_t'(it.command))
      CMD_RESET: begin
        clear_filter();
        m_origin = it.now;
      end
      CMD_NODATA: m_unreadable = 1;
      CMD_OFFER: begin
        if (!m_has_last || m_last_q != it.quality ||
            (mx != '0 && 64'(since_pub(it.now)) >= mx)) begin
          store_pub(rd, it.quality, it.now);
          return pub_item(rd, it.quality);
        end
        chg = differs(rd, m_last);
        if (c_deb != '0) begin
          if (!chg) begin
            m_has_cand = 0;
            m_has_pend = 0;
            return r;
          end
          m_latest = rd;
          if (m_has_cand && !differs(rd, m_first)) begin
            if (gap(it.now, m_cand_since) < 63'(c_deb)) return r;
            m_has_cand = 0;
          end else begin
            m_first      = rd;
            m_cand_since = it.now;
            m_has_cand   = 1;
            return r;
          end
        end
        if (c_min != '0 && since_pub(it.now) < 63'(c_min)) begin
          m_pend     = rd;
          m_has_pend = 1;
          return r;
        end
        m_has_pend = 0;
        if (filters_on() && !chg) return r;
        store_pub(rd, it.quality, it.now);
        return pub_item(rd, it.quality);
      end
      default: begin
        pub  = 0;
        rr   = 0;
        held = '0;
        if (c_min != '0 && m_has_pend && since_pub(it.now) >= 63'(c_min)) begin
          held       = m_pend;
          m_has_pend = 0;
          pub        = release_held(held, it.now);
        end
        if (!pub && c_deb != '0 && m_has_cand &&
            gap(it.now, m_cand_since) >= 63'(c_deb)) begin
          held       = m_latest;
          m_has_cand = 0;
          if (c_min != '0 && since_pub(it.now) < 63'(c_min)) begin
            m_pend     = held;
            m_has_pend = 1;
          end else begin
            pub = release_held(held, it.now);
          end
        end
        if (mx != '0) begin
          refp = m_has_last ? m_last_pub : m_origin;
          ra   = m_has_read ? m_last_read : m_origin;
          if (ra > refp) refp = ra;
          if (it.pushed && !m_unreadable && 64'(gap(it.now, refp)) >= mx) begin
            m_last_read = it.now;
            m_has_read  = 1;
            rr          = 1;
          end
        end
        if (pub) r = pub_item(held, m_last_q);
        r.read_request = rr;
      end
    endcase
    return r;
  endfunction

  // predictor and checker
  always @(posedge clk) begin
    out_item_t e;
    out_item_t a;
    if (!rst_n) begin
      clear_filter();
      c_chg_only = 0; c_mode = '0; c_amount = '0; c_min = '0; c_max = '0; c_deb = '0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_CHG_ONLY:  c_chg_only  = cfg_data[0];
          REG_DB_MODE:   c_mode      = cfg_data[1:0];
          REG_DB_AMOUNT: c_amount    = cfg_data[AMT_BITS-1:0];
          REG_MIN_IVL:   c_min       = cfg_data[IVL_BITS-1:0];
          REG_MAX_IVL:   c_max       = cfg_data[IVL_BITS-1:0];
          REG_DEBOUNCE:  c_deb       = cfg_data[IVL_BITS-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) report_q.push_back(predict_report(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        if (report_q.size() == 0) begin
          $display("%0t: unexpected item %h", $time, a);
          fails++;
        end else begin
          e = report_q.pop_front();
          if (e.published != a.published) begin
            $display("%0t: published exp %0d got %0d", $time, e.published, a.published);
            fails++;
          end
          if (e.read_request != a.read_request) begin
            $display("%0t: read_request exp %0d got %0d", $time, e.read_request,
                     a.read_request);
            fails++;
          end
          if (e.out_is_num != a.out_is_num) begin
            $display("%0t: out_is_num exp %0d got %0d", $time, e.out_is_num, a.out_is_num);
            fails++;
          end
          if (e.out_is_nan != a.out_is_nan) begin
            $display("%0t: out_is_nan exp %0d got %0d", $time, e.out_is_nan, a.out_is_nan);
            fails++;
          end
          if (e.out_value != a.out_value) begin
            $display("%0t: out_value exp %h got %h", $time, e.out_value, a.out_value);
            fails++;
          end
          if (e.out_code != a.out_code) begin
            $display("%0t: out_code exp %h got %h", $time, e.out_code, a.out_code);
            fails++;
          end
          if (e.out_quality != a.out_quality) begin
            $display("%0t: out_quality exp %0d got %0d", $time, e.out_quality,
                     a.out_quality);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
    cycles  <= cycles + 1;
    calm    <= (cycles > 3000 && cycles < 6000);
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // item driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (item_q.size() > 0 && !pause_tx && (calm || $urandom_range(0, 99) >= 22)) begin
        in_ch.data  <= item_q.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver with one long hold-off
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done     <= 1'b1;
      hold_left     <= 300;
      out_ch.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= rst_n && (calm || $urandom_range(0, 99) >= 22);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_config(logic oc, logic [1:0] mode, logic [AMT_BITS-1:0] amt,
                            logic [IVL_BITS-1:0] mn, logic [IVL_BITS-1:0] mx,
                            logic [IVL_BITS-1:0] db);
    write_reg(REG_CHG_ONLY, CFG_BITS'(oc));
    write_reg(REG_DB_MODE, CFG_BITS'(mode));
    write_reg(REG_DB_AMOUNT, CFG_BITS'(amt));
    write_reg(REG_MIN_IVL, CFG_BITS'(mn));
    write_reg(REG_MAX_IVL, CFG_BITS'(mx));
    write_reg(REG_DEBOUNCE, CFG_BITS'(db));
  endtask

  task automatic wait_drained();
    while (item_q.size() > 0 || in_ch.valid || report_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] cmd, logic [TIME_BITS-1:0] now,
                                         logic num, logic nan,
                                         logic signed [VALUE_BITS-1:0] v,
                                         logic [CODE_BITS-1:0] code, logic [1:0] q,
                                         logic push);
    in_item_t it;
    it.command        = cmd;
    it.now            = now;
    it.reading_is_num = num;
    it.reading_is_nan = nan;
    it.reading_value  = v;
    it.reading_code   = code;
    it.quality        = q;
    it.pushed         = push;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int unsigned                  k;
    logic [1:0]                   cmd;
    logic signed [VALUE_BITS-1:0] v;
    logic [CODE_BITS-1:0]         code;
    k = $urandom_range(0, 99);
    if (k < 2) t_now = TIME_BITS'({$urandom, $urandom});
    else if (k < 5) t_now = t_now - 63'($urandom_range(0, 500));
    else t_now = t_now + 63'($urandom_range(0, int'(t_span)));
    k   = $urandom_range(0, 99);
    cmd = (k < 62) ? CMD_OFFER : (k < 90) ? CMD_DUE : (k < 94) ? CMD_NODATA : CMD_RESET;
    k = $urandom_range(0, 99);
    if (k < 40) v = base_val + 48'(signed'($urandom_range(0, 6 << 16)) - (3 << 16));
    else if (k < 60) v = base_val;
    else if (k < 75) v = VALUE_BITS'({$urandom, $urandom});
    else if (k < 80) v = {1'b0, {(VALUE_BITS-1){1'b1}}};
    else if (k < 85) v = {1'b1, {(VALUE_BITS-1){1'b0}}};
    else if (k < 88) v = '0;
    else v = 48'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
    if ($urandom_range(0, 9) < 3) base_val = v;
    code = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
           base_code + 64'($urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) cur_q = 2'($urandom_range(0, 3));
    return make_item(cmd, t_now, $urandom_range(0, 9) < 8, $urandom_range(0, 9) == 0, v,
                     code, cur_q, $urandom_range(0, 3) != 0);
  endfunction

  task automatic run_random(int n);
    repeat (n) item_q.push_back(rand_item());
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    fails       = 0;
    cycles      = 0;
    in_fire     = 1'b0;
    pause_tx    = 1'b0;
    hold_go     = 1'b0;
    hold_done   = 1'b0;
    hold_left   = 0;
    calm        = 1'b0;
    t_now       = 63'd1000;
    t_span      = 200;
    base_val    = 48'sd5 <<< 16;
    base_code   = 64'h1234;
    cur_q       = 2'd1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults, then directed corner items
    set_config(1'b0, MODE_ABS, 47'd1 << 16, 62'd0, 62'd0, 62'd0);
    item_q.push_back(make_item(CMD_OFFER, 63'd10, 1'b1, 1'b0, {1'b0, {47{1'b1}}}, '0, 2'd0,
                               1'b0));
    item_q.push_back(make_item(CMD_OFFER, 63'd20, 1'b1, 1'b0, {1'b1, {47{1'b0}}}, '0, 2'd0,
                               1'b0));
    item_q.push_back(make_item(CMD_OFFER, 63'd30, 1'b1, 1'b0, 48'sd100, '0, 2'd0, 1'b0));
    item_q.push_back(make_item(CMD_OFFER, 63'd40, 1'b1, 1'b0, '0, '1, 2'd0, 1'b1));
    item_q.push_back(make_item(CMD_OFFER, 63'd50, 1'b1, 1'b1, 48'sd7, '1, 2'd0, 1'b0));
    item_q.push_back(make_item(CMD_OFFER, 63'd60, 1'b1, 1'b1, 48'sd9, '0, 2'd0, 1'b0));
    item_q.push_back(make_item(CMD_OFFER, 63'd70, 1'b0, 1'b1, '1, '1, 2'd0, 1'b0));
    item_q.push_back(make_item(CMD_OFFER, 63'd80, 1'b0, 1'b0, '1, '1, 2'd0, 1'b0));
    item_q.push_back(make_item(CMD_OFFER, 63'd90, 1'b0, 1'b0, '0, '0, 2'd0, 1'b0));
    item_q.push_back(make_item(CMD_OFFER, 63'd95, 1'b0, 1'b0, '0, '0, 2'd3, 1'b0));
    item_q.push_back(make_item(CMD_OFFER, 63'd96, 1'b1, 1'b0, 48'sd1, '0, 2'd2, 1'b0));
    item_q.push_back(make_item(CMD_OFFER, 63'd97, 1'b1, 1'b0, 48'sd1, '0, 2'd1, 1'b0));
    item_q.push_back(make_item(CMD_DUE, 63'd100, 1'b0, 1'b0, '0, '0, 2'd0, 1'b1));
    item_q.push_back(make_item(CMD_DUE, 63'd50, 1'b0, 1'b0, '0, '0, 2'd0, 1'b0));
    item_q.push_back(make_item(CMD_NODATA, 63'd110, 1'b1, 1'b1, '1, '1, 2'd3, 1'b1));
    item_q.push_back(make_item(CMD_DUE, 63'd120, 1'b0, 1'b0, '0, '0, 2'd0, 1'b1));
    item_q.push_back(make_item(CMD_RESET, '1, 1'b1, 1'b1, '1, '1, 2'd3, 1'b1));
    item_q.push_back(make_item(CMD_OFFER, '1, 1'b1, 1'b0, 48'sd3, '0, 2'd2, 1'b0));
    item_q.push_back(make_item(CMD_RESET, 63'd0, 1'b0, 1'b0, '0, '0, 2'd0, 1'b0));
    item_q.push_back(make_item(CMD_OFFER, 63'd5, 1'b1, 1'b0, -48'sd3, '0, 2'd1, 1'b0));
    wait_drained();
    run_random(130);
    wait_drained();

    set_config(1'b1, MODE_PCT, 47'd10 << 16, 62'd500, 62'd3000, 62'd0);
    t_span = 400;
    hold_go = 1'b1;
    run_random(150);
    wait_drained();

    set_config(1'b0, MODE_NONE, 47'd0, 62'd200, 62'd0, 62'd300);
    t_span = 150;
    run_random(75);
    while (item_q.size() > 50) @(posedge clk);
    pause_tx = 1'b1;
    while (in_ch.valid || report_q.size() > 0) @(posedge clk);
    pause_tx = 1'b0;
    wait_drained();
    run_random(75);
    wait_drained();

    set_config(1'b0, MODE_ABS, 47'd1 << 15, 62'd1000, 62'd800, 62'd200);
    t_span = 600;
    run_random(150);
    wait_drained();

    set_config(1'b1, 2'd3, {AMT_BITS{1'b1}}, {IVL_BITS{1'b1}}, {IVL_BITS{1'b1}},
               {IVL_BITS{1'b1}});
    t_now = {1'b1, 62'd0};
    t_span = 32'h7fff_ffff;
    run_random(60);
    wait_drained();
    set_config(1'b0, MODE_PCT, {AMT_BITS{1'b1}}, 62'd1, {IVL_BITS{1'b1}}, 62'd1);
    run_random(60);
    wait_drained();

    repeat (3) begin
      set_config(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 47'($urandom_range(0, 8 << 16)), 62'($urandom_range(0, 800)),
                 62'($urandom_range(0, 4000)), 62'($urandom_range(0, 500)));
      t_now  = 63'($urandom);
      t_span = $urandom_range(50, 700);
      run_random(100);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
